### src/tos_pkg.sv
// ----------------------------------------------------------------------------
// tos_pkg
// shared constants, types and conversion helpers for the typed operand stack
// ----------------------------------------------------------------------------
package tos_pkg;

    localparam int STACK_BYTES = 4096;
    localparam int WORD_COUNT  = STACK_BYTES / 4;
    localparam int ADDR_W      = $clog2(WORD_COUNT);
    localparam int OFF_W       = 13;
    localparam int DATA_W      = 32;

    localparam logic [7:0] TAG_INT   = 8'h69;
    localparam logic [7:0] TAG_FLOAT = 8'h66;

    localparam logic [OFF_W-1:0] STACK_END = OFF_W'(STACK_BYTES);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_ENTER = 2'd2,
        OP_LEAVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_INT   = 2'd1,
        KIND_FLOAT = 2'd2,
        KIND_RSVD  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_CVT1,
        S_CVT2,
        S_WR2,
        S_OUT
    } state_t;

    // float to int, truncating
    function automatic logic [31:0] f2i(input logic [31:0] b);
        logic [7:0]  e;
        logic [63:0] m;
        logic [31:0] mag;
        begin
            e   = b[30:23];
            m   = {40'd0, 1'b1, b[22:0]};
            mag = 32'd0;
            if (e < 8'd127)
                f2i = 32'd0;
            else if (e >= 8'd158)
                f2i = (b == 32'hcf000000) ? 32'h80000000 : 32'h80000000;
            else
            begin
                if (e >= 8'd150)
                    mag = 32'(m << (e - 8'd150));
                else
                    mag = 32'(m >> (8'd150 - e));
                f2i = b[31] ? (32'd0 - mag) : mag;
            end
        end
    endfunction

    // position of leading one, 0 if none
    function automatic logic [4:0] lead_one(input logic [31:0] v);
        logic [4:0] p;
        begin
            p = 5'd0;
            for (int i = 0; i < 32; i++)
                if (v[i])
                    p = 5'(i);
            lead_one = p;
        end
    endfunction

endpackage

### src/tos_ram.sv
// ----------------------------------------------------------------------------
// tos_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module tos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

### src/typed_operand_stack.sv
// ----------------------------------------------------------------------------
// typed_operand_stack
// byte-addressed word stack with typed push/pop and frame enter/leave
// ----------------------------------------------------------------------------
// channel  dir  handshake              contents
// s_axis   in   tvalid/tready          op, kind, push_word, local_bytes
// m_axis   out  tvalid/tready          pop_word, status, top_now, base_now
//
// one beat in progress; a new item is taken only once the last result is loaded into the output register.
// after reset a clearing pass zeroes all 1024 ram words, input held off.
// a typed pop reads value then tag; int to float conversion adds the S_CVT1 and S_CVT2 states.
// a typed push reads the tag word, then writes it and the value word.
// output register holds the result while m_axis_tready is low.
module typed_operand_stack (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], kind[3:2], push_word[35:4], local_bytes[48:36], pad
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pop_word[31:0], status[33:32], top_now[46:34], base_now[59:47], pad
    output logic [63:0] m_axis_tdata
);
    import tos_pkg::*;

    state_t             state_reg, state_next;
    logic [ADDR_W:0]    clr_reg, clr_next;
    logic [OFF_W-1:0]   top_reg, top_next, base_reg, base_next;
    logic [1:0]         op_reg, op_next;
    logic [7:0]         tag_reg, tag_next;
    logic [31:0]        word_reg, word_next;
    logic [31:0]        res_reg, res_next;
    logic [1:0]         st_reg, st_next;
    logic [31:0]        cv_reg, cv_next;
    logic [4:0]         lz_reg, lz_next;
    logic               sg_reg, sg_next;
    logic               mv_reg, mv_next;
    logic [63:0]        out_reg, out_next;

    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [31:0]        wdata, rdata;

    tos_ram #(.WIDTH(DATA_W), .DEPTH(WORD_COUNT)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    logic [1:0]       in_op;
    logic [7:0]       in_tag;
    logic [31:0]      in_word;
    logic [OFF_W-1:0] in_loc, legal;
    logic [OFF_W:0]   ltop;
    logic [31:0]      rnd;
    logic [7:0]       ex;
    logic [31:0]      sh;
    logic             g, st, lsb;
    logic [24:0]      mant;

    assign in_op   = s_axis_tdata[1:0];
    assign in_tag  = (s_axis_tdata[3:2] == KIND_INT) ? TAG_INT :
                     (s_axis_tdata[3:2] == KIND_FLOAT) ? TAG_FLOAT : 8'd0;
    assign in_word = s_axis_tdata[35:4];
    assign in_loc  = {s_axis_tdata[48:38], 2'b00};
    assign ltop    = {1'b0, top_reg} + {1'b0, in_loc};
    assign legal   = (rdata > 32'(STACK_BYTES)) ? STACK_END : {rdata[OFF_W-1:2], 2'b00};

    always_comb
    begin
        sh   = cv_reg << (5'd31 - lz_reg);
        g    = sh[7];
        st   = |sh[6:0];
        lsb  = sh[8];
        mant = {1'b0, sh[31:8]} + 25'((g && (st || lsb)) ? 1 : 0);
        ex   = 8'd127 + {3'd0, lz_reg} + (mant[24] ? 8'd1 : 8'd0);
        rnd  = (cv_reg == 32'd0) ? 32'd0 :
               {sg_reg, ex, mant[24] ? mant[23:1] : mant[22:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            clr_reg   <= '0;
            top_reg   <= '0;
            base_reg  <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            top_reg   <= top_next;
            base_reg  <= base_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        tag_reg  <= tag_next;
        word_reg <= word_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        cv_reg   <= cv_next;
        lz_reg   <= lz_next;
        sg_reg   <= sg_next;
        out_reg  <= out_next;
    end

    assign s_axis_tready = clr_reg[ADDR_W] && state_reg == S_IDLE;
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        top_next   = top_reg;
        base_next  = base_reg;
        op_next    = op_reg;
        tag_next   = tag_reg;
        word_next  = word_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        cv_next    = cv_reg;
        lz_next    = lz_reg;
        sg_next    = sg_reg;
        out_next   = out_reg;
        mv_next    = mv_reg && !m_axis_tready;
        we         = 1'b0;
        addr       = top_reg[ADDR_W+1:2];
        wdata      = word_reg;
        if (!clr_reg[ADDR_W])
        begin
            we       = 1'b1;
            addr     = clr_reg[ADDR_W-1:0];
            wdata    = '0;
            clr_next = clr_reg + 1'b1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        op_next   = in_op;
                        tag_next  = in_tag;
                        word_next = in_word;
                        res_next  = '0;
                        st_next   = ST_OK;
                        state_next = S_OUT;
                        case (in_op)
                            OP_PUSH:
                            begin
                                if (top_reg + 13'd4 >= STACK_END)
                                    st_next = ST_OVER;
                                else if (in_tag != 8'd0)
                                    state_next = S_RD1;
                                else
                                begin
                                    we       = 1'b1;
                                    wdata    = in_word;
                                    top_next = top_reg + 13'd4;
                                end
                            end
                            OP_POP:
                            begin
                                if (top_reg < ((in_tag != 8'd0) ? 13'd8 : 13'd4))
                                    st_next = ST_UNDER;
                                else
                                begin
                                    top_next   = top_reg - 13'd4;
                                    addr       = top_next[ADDR_W+1:2];
                                    state_next = S_RD1;
                                end
                            end
                            OP_ENTER:
                            begin
                                if (ltop >= {1'b0, STACK_END})
                                    st_next = ST_OVER;
                                else
                                begin
                                    if (ltop + 14'd4 < {1'b0, STACK_END})
                                    begin
                                        we       = 1'b1;
                                        addr     = ltop[ADDR_W+1:2];
                                        wdata    = {19'd0, base_reg};
                                        top_next = ltop[OFF_W-1:0] + 13'd4;
                                    end
                                    else
                                        top_next = ltop[OFF_W-1:0];
                                    word_next = {19'd0, top_reg};
                                    state_next = S_WR2;
                                end
                            end
                            default:
                            begin
                                word_next = {19'd0, base_reg};
                                if (top_reg >= 13'd4)
                                begin
                                    addr       = ADDR_W'(top_reg - 13'd4 >> 2);
                                    state_next = S_RD1;
                                end
                                else
                                    top_next = base_reg;
                            end
                        endcase
                    end
                end
                S_RD1:
                begin
                    state_next = S_OUT;
                    case (op_reg)
                        OP_PUSH:
                        begin
                            we       = 1'b1;
                            wdata    = {rdata[31:8], tag_reg};
                            top_next = top_reg + 13'd4;
                            state_next = S_WR2;
                        end
                        OP_POP:
                        begin
                            res_next = rdata;
                            if (tag_reg != 8'd0)
                            begin
                                top_next   = top_reg - 13'd4;
                                addr       = top_next[ADDR_W+1:2];
                                state_next = S_RD2;
                            end
                        end
                        default:
                        begin
                            base_next = legal;
                            top_next  = word_reg[OFF_W-1:0];
                        end
                    endcase
                end
                S_WR2:
                begin
                    if (op_reg == OP_PUSH)
                    begin
                        we       = 1'b1;
                        wdata    = word_reg;
                        top_next = top_reg + 13'd4;
                    end
                    else
                        base_next = word_reg[OFF_W-1:0];
                    state_next = S_OUT;
                end
                S_RD2:
                begin
                    state_next = S_OUT;
                    if (rdata[7:0] == TAG_FLOAT && tag_reg == TAG_INT)
                        res_next = f2i(res_reg);
                    else if (rdata[7:0] == TAG_INT && tag_reg == TAG_FLOAT)
                    begin
                        sg_next    = res_reg[31];
                        cv_next    = res_reg[31] ? (32'd0 - res_reg) : res_reg;
                        state_next = S_CVT1;
                    end
                end
                S_CVT1:
                begin
                    lz_next    = lead_one(cv_reg);
                    state_next = S_CVT2;
                end
                S_CVT2:
                begin
                    res_next   = rnd;
                    state_next = S_OUT;
                end
                S_OUT:
                begin
                    if (!mv_reg || m_axis_tready)
                    begin
                        out_next   = {4'd0, base_reg, top_reg, st_reg, res_reg};
                        mv_next    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                default:
                    state_next = S_IDLE;
            endcase
        end
    end

    a_top_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg[1:0] == 2'b00) else $error("top misaligned");
    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= STACK_END) else $error("top out of range");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && !m_axis_tready) |=> $stable(out_reg)) else $error("result changed");

endmodule
